FILE: design/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared widths, codes and types for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 31;
  localparam int unsigned PEND_W = 3;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // lead byte class masks and patterns
  localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD5_MASK = 8'hFC;
  localparam logic [BYTE_W-1:0] LEAD5_PAT  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD6_MASK = 8'hFE;
  localparam logic [BYTE_W-1:0] LEAD6_PAT  = 8'hFC;

  localparam logic [PEND_W-1:0] PEND_MAX = 3'd5;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            status;
    logic            string_done;
  } res_t;

endpackage

FILE: design/u8d_if.sv
// ----------------------------------------------------------------------------
// u8d_in_if / u8d_out_if
// Valid/ready channels carrying raw bytes in and decoded characters out.
// ----------------------------------------------------------------------------
interface u8d_in_if;
  logic                          valid;
  logic                          ready;
  logic [u8d_pkg::BYTE_W-1:0]    data_byte;
  logic                          end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface u8d_out_if;
  logic                          valid;
  logic                          ready;
  logic [u8d_pkg::CP_W-1:0]      code_point;
  logic                          status;
  logic                          string_done;

  modport source (output valid, output code_point, output status, output string_done,
                  input ready);
  modport sink   (input valid, input code_point, input status, input string_done,
                  output ready);
endinterface

FILE: design/utf8_byte_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Decodes a UTF-8 byte stream (one to six byte forms) into code points.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one raw byte per request, with end_of_string on the last byte
//            of a string.
//   out_ch : one request per finished character or per malformed sequence
//            (status = 1, code_point = 0, string_done = 1).
//   A byte is taken every cycle while the skid register is empty; the sequence
//   state (pending count, partial value, failed flag) is updated in the same
//   cycle as the byte is taken. A result is registered in the output register,
//   or in the skid register while the receiver stalls. Throughput: one byte
//   per cycle while in_ch.ready is high, set by the combinational decode.
//   After an error the remaining bytes of the string are swallowed without
//   results up to and including the byte marked end_of_string.
//   When the receiver stalls, one further result is held in a skid register;
//   in_ch.ready drops only while that skid register is occupied.
//   Reset (rst_n low, synchronous) clears the sequence state and empties
//   both output registers.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder (
  input  logic          clk,
  input  logic          rst_n,
  u8d_in_if.sink        in_ch,
  u8d_out_if.source     out_ch
);

  logic [u8d_pkg::PEND_W-1:0] pending_r, pending_nxt;
  logic [u8d_pkg::CP_W-1:0]   partial_r, partial_nxt;
  logic                       failed_r, failed_nxt;

  logic                       out_valid_r, skid_valid_r;
  u8d_pkg::res_t              out_r, skid_r;

  logic                       in_fire, out_fire, res_valid;
  u8d_pkg::res_t              res;
  logic [u8d_pkg::BYTE_W-1:0] b;
  logic                       eos;

  assign b        = in_ch.data_byte;
  assign eos      = in_ch.end_of_string;
  assign in_ch.ready = !skid_valid_r;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;

  // decode of one byte against the current sequence state
  always_comb begin
    pending_nxt     = pending_r;
    partial_nxt     = partial_r;
    failed_nxt      = failed_r;
    res_valid       = 1'b0;
    res.code_point  = '0;
    res.status      = u8d_pkg::STATUS_ERR;
    res.string_done = 1'b1;
    if (failed_r) begin
      if (eos) failed_nxt = 1'b0;
    end else if (pending_r != '0) begin
      if ((b & u8d_pkg::CONT_MASK) != u8d_pkg::CONT_PAT) begin
        pending_nxt = '0;
        partial_nxt = '0;
        failed_nxt  = !eos;
        res_valid   = 1'b1;
      end else if (pending_r == 3'd1) begin
        pending_nxt     = '0;
        partial_nxt     = '0;
        res_valid       = 1'b1;
        res.code_point  = {partial_r[u8d_pkg::CP_W-7:0], b[5:0]};
        res.status      = u8d_pkg::STATUS_OK;
        res.string_done = eos;
      end else if (eos) begin
        // string ends with continuation bytes still owed
        pending_nxt = '0;
        partial_nxt = '0;
        res_valid   = 1'b1;
      end else begin
        pending_nxt = pending_r - 3'd1;
        partial_nxt = {partial_r[u8d_pkg::CP_W-7:0], b[5:0]};
      end
    end else if ((b & u8d_pkg::ASCII_MASK) == '0) begin
      res_valid       = 1'b1;
      res.code_point  = {{(u8d_pkg::CP_W-u8d_pkg::BYTE_W){1'b0}}, b};
      res.status      = u8d_pkg::STATUS_OK;
      res.string_done = eos;
    end else begin
      priority if ((b & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_PAT) begin
        pending_nxt = 3'd1;
        partial_nxt = {{(u8d_pkg::CP_W-5){1'b0}}, b[4:0]};
      end else if ((b & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_PAT) begin
        pending_nxt = 3'd2;
        partial_nxt = {{(u8d_pkg::CP_W-4){1'b0}}, b[3:0]};
      end else if ((b & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_PAT) begin
        pending_nxt = 3'd3;
        partial_nxt = {{(u8d_pkg::CP_W-3){1'b0}}, b[2:0]};
      end else if ((b & u8d_pkg::LEAD5_MASK) == u8d_pkg::LEAD5_PAT) begin
        pending_nxt = 3'd4;
        partial_nxt = {{(u8d_pkg::CP_W-2){1'b0}}, b[1:0]};
      end else if ((b & u8d_pkg::LEAD6_MASK) == u8d_pkg::LEAD6_PAT) begin
        pending_nxt = u8d_pkg::PEND_MAX;
        partial_nxt = {{(u8d_pkg::CP_W-1){1'b0}}, b[0]};
      end else begin
        // stray continuation byte or 0xFE/0xFF
        pending_nxt = '0;
        partial_nxt = '0;
        failed_nxt  = !eos;
        res_valid   = 1'b1;
      end
      if (res_valid == 1'b0 && eos) begin
        // lead byte on the last byte of the string
        pending_nxt = '0;
        partial_nxt = '0;
        res_valid   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      partial_r <= '0;
      failed_r  <= 1'b0;
    end else if (in_fire) begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
      failed_r  <= failed_nxt;
    end
  end

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_point  = out_r.code_point;
  assign out_ch.status      = out_r.status;
  assign out_ch.string_done = out_r.string_done;

  // a held skid entry always sits behind a held output entry
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register occupied while output register empty");

  a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= u8d_pkg::PEND_MAX)
    else $error("pending count out of range");

  a_failed_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (pending_r == '0))
    else $error("sequence open while string marked failed");

  a_err_zero_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == u8d_pkg::STATUS_ERR) |->
      (out_r.code_point == '0 && out_r.string_done))
    else $error("error result with nonzero code point or string not done");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ch.ready) |=> (skid_valid_r && $stable(skid_r)))
    else $error("skid entry lost under stall");

endmodule
